// ===== sv/bat_pkg.sv =====
// shared constants and types for the block allocation table engine
// no dependencies; imported by block_alloc_table_engine
`timescale 1ns / 1ps
`default_nettype none

package bat_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int STEP_W      = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CNT_W       = (CFG_W > STEP_W) ? CFG_W : STEP_W;
    localparam int MODE_W      = 3;
    localparam int ENTRY_W     = 16;
    localparam int TOTAL_W     = 9;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic [ENTRY_W-1:0] FREE_MARK = 16'hFFFC;
    localparam logic [ENTRY_W-1:0] END_MARK  = 16'hFFFA;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT   = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 3'd0,
        MODE_WRITE = 3'd1,
        MODE_COUNT = 3'd2,
        MODE_FIND  = 3'd3,
        MODE_CHAIN = 3'd4,
        MODE_CLEAR = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_SCAN,
        S_CHAIN_RD,
        S_CHAIN_WB,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/block_alloc_table_engine.sv =====
// block allocation table engine: 16-bit link table in one synchronous ram
// plus per-entry valid bits, with scan and chain-walk sequencer; uses bat_pkg
// steps: read does one ram read, count scans entries 0 to block_count - 1,
//   find scans downward from block_count - 1 and stops at the first free entry,
//   free chain reads each link, then clears its valid bit (at most MAX_ENTRIES links)
// throughput: one item at a time, set by the single ram read port
// reset (i_rst_n low, synchronous): all entries read as free marker via
//   cleared valid bits at once, modified mark 0, both registers 256
`timescale 1ns / 1ps
`default_nettype none

module block_alloc_table_engine (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // fields from bit 0: mode[2:0], entry_index[18:3], entry_value[34:19], zero pad
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [bat_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // fields from bit 0: read_value[15:0], free_total[24:16], found_block[40:25],
    // modified_flag[41], chain_fault[42], zero pad
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [bat_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire                                i_cfg_we,
    input  wire  [bat_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [bat_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import bat_pkg::*;

    // configuration
    logic [CFG_W-1:0]   r_tbl_ent, r_blk_cnt;

    // control and working registers
    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [ENTRY_W-1:0] r_idx, n_idx;
    logic [ENTRY_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]   r_eff, n_eff;
    logic [CNT_W-1:0]   r_bc, n_bc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_chk, n_chk;
    logic               r_chk_oot, n_chk_oot;
    logic [CNT_W-1:0]   r_chk_idx, n_chk_idx;
    logic [ENTRY_W-1:0] r_next, n_next;
    logic               r_mark, n_mark;
    logic [ENTRY_W-1:0] r_res_rd, n_res_rd;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [ENTRY_W-1:0] r_found, n_found;
    logic               r_fault, n_fault;
    logic               r_out_vld, n_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // memory
    logic [ENTRY_W-1:0]     mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_vld;
    logic [ENTRY_W-1:0]     r_rd_data;
    logic                   r_rd_vld;
    logic [ADDR_W-1:0]      w_addr;
    logic                   w_mem_we;
    logic                   w_vld_clr;

    logic [ENTRY_W-1:0] w_rd_val;
    logic               w_free;
    logic [CNT_W-1:0]   w_dn;
    logic [ENTRY_W-1:0] w_te16;
    logic               w_accept;
    logic               w_in_tbl;
    logic               w_chain_end;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // an entry without its valid bit reads as the free marker
    assign w_rd_val = r_rd_vld ? r_rd_data : FREE_MARK;
    assign w_free   = r_chk_oot || (w_rd_val == FREE_MARK);
    assign w_dn     = r_cnt - CNT_W'(1);
    assign w_te16   = ENTRY_W'(r_tbl_ent);
    assign w_in_tbl = r_idx < ENTRY_W'(r_eff);
    assign w_chain_end = (r_next == END_MARK) || (r_next == FREE_MARK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_ent <= CFG_RESET;
            r_blk_cnt <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TABLE_ENTRIES: r_tbl_ent <= i_cfg_wdata;
                REG_BLOCK_COUNT:   r_blk_cnt <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_idx      = r_idx;
        n_val      = r_val;
        n_eff      = r_eff;
        n_bc       = r_bc;
        n_cnt      = r_cnt;
        n_chk      = 1'b0;
        n_chk_oot  = r_chk_oot;
        n_chk_idx  = r_chk_idx;
        n_next     = r_next;
        n_mark     = r_mark;
        n_res_rd   = r_res_rd;
        n_total    = r_total;
        n_found    = r_found;
        n_fault    = r_fault;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_data = r_out_data;
        w_addr     = r_idx[ADDR_W-1:0];
        w_mem_we   = 1'b0;
        w_vld_clr  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode   = t_mode'(s_axis_tdata[MODE_W-1:0]);
                    n_idx    = s_axis_tdata[MODE_W +: ENTRY_W];
                    n_val    = s_axis_tdata[MODE_W+ENTRY_W +: ENTRY_W];
                    n_eff    = (w_te16 > ENTRY_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                                : CNT_W'(r_tbl_ent);
                    n_bc     = CNT_W'(r_blk_cnt);
                    n_res_rd = '0;
                    n_total  = '0;
                    n_fault  = 1'b0;
                    n_next   = s_axis_tdata[MODE_W +: ENTRY_W];
                    n_found  = (t_mode'(s_axis_tdata[MODE_W-1:0]) == MODE_FIND)
                               ? FREE_MARK : '0;
                    n_cnt    = (t_mode'(s_axis_tdata[MODE_W-1:0]) == MODE_FIND)
                               ? CNT_W'(r_blk_cnt) : '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_chk_oot = !w_in_tbl;
                unique case (r_mode)
                    MODE_READ: begin
                        n_state = S_RDATA;
                    end
                    MODE_WRITE: begin
                        if (w_in_tbl) begin
                            w_mem_we = 1'b1;
                            n_mark   = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    MODE_COUNT, MODE_FIND: begin
                        n_state = S_SCAN;
                    end
                    MODE_CHAIN: begin
                        n_state = S_CHAIN_RD;
                    end
                    MODE_CLEAR: begin
                        n_mark  = 1'b0;
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RDATA: begin
                n_res_rd = r_chk_oot ? FREE_MARK : w_rd_val;
                n_state  = S_DONE;
            end
            S_SCAN: begin
                if (r_mode == MODE_COUNT) begin
                    w_addr = r_cnt[ADDR_W-1:0];
                    if (r_chk && w_free) begin
                        n_total = r_total + TOTAL_W'(1);
                    end
                    if (r_cnt != r_bc) begin
                        n_chk     = 1'b1;
                        n_chk_oot = r_cnt >= r_eff;
                        n_chk_idx = r_cnt;
                        n_cnt     = r_cnt + CNT_W'(1);
                    end else if (!r_chk) begin
                        n_state = S_DONE;
                    end
                end else begin
                    // descending search, one read in flight; stop on first free
                    w_addr = w_dn[ADDR_W-1:0];
                    if (r_chk && w_free) begin
                        n_found = ENTRY_W'(r_chk_idx);
                        n_state = S_DONE;
                    end else if (r_cnt != '0) begin
                        n_chk     = 1'b1;
                        n_chk_oot = w_dn >= r_eff;
                        n_chk_idx = w_dn;
                        n_cnt     = w_dn;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CHAIN_RD: begin
                w_addr = r_next[ADDR_W-1:0];
                priority if (w_chain_end) begin
                    n_state = S_DONE;
                end else if (r_cnt >= CNT_W'(MAX_ENTRIES)) begin
                    n_fault = 1'b1;
                    n_state = S_DONE;
                end else if (r_next >= ENTRY_W'(r_eff)) begin
                    // link leaves the table: reads as free, nothing stored
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHAIN_WB;
                end
            end
            S_CHAIN_WB: begin
                w_addr    = r_next[ADDR_W-1:0];
                w_vld_clr = 1'b1;
                n_mark    = 1'b1;
                n_next    = w_rd_val;
                n_cnt     = r_cnt + CNT_W'(1);
                n_state   = S_CHAIN_RD;
            end
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {5'b0, r_fault, r_mark, r_found, r_total, r_res_rd};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= MODE_READ;
            r_idx      <= '0;
            r_val      <= '0;
            r_eff      <= '0;
            r_bc       <= '0;
            r_cnt      <= '0;
            r_chk      <= 1'b0;
            r_chk_oot  <= 1'b0;
            r_chk_idx  <= '0;
            r_next     <= '0;
            r_mark     <= 1'b0;
            r_res_rd   <= '0;
            r_total    <= '0;
            r_found    <= '0;
            r_fault    <= 1'b0;
            r_out_vld  <= 1'b0;
            r_out_data <= '0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_idx      <= n_idx;
            r_val      <= n_val;
            r_eff      <= n_eff;
            r_bc       <= n_bc;
            r_cnt      <= n_cnt;
            r_chk      <= n_chk;
            r_chk_oot  <= n_chk_oot;
            r_chk_idx  <= n_chk_idx;
            r_next     <= n_next;
            r_mark     <= n_mark;
            r_res_rd   <= n_res_rd;
            r_total    <= n_total;
            r_found    <= n_found;
            r_fault    <= n_fault;
            r_out_vld  <= n_out_vld;
            r_out_data <= n_out_data;
        end
    end

    // link table ram, one port, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_addr] <= r_val;
        end
        r_rd_data <= mem[w_addr];
    end

    // valid bits: set by a write, cleared by reset or when a chain entry is freed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_mem_we) begin
                r_vld[w_addr] <= 1'b1;
            end else if (w_vld_clr) begin
                r_vld[w_addr] <= 1'b0;
            end
            r_rd_vld <= r_vld[w_addr];
        end
    end

`ifndef SYNTHESIS
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_mode == MODE_COUNT) |-> (r_cnt <= r_bc))
        else $error("count scan ran past block count");

    a_fault_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |-> (r_cnt == CNT_W'(MAX_ENTRIES)))
        else $error("chain fault before step limit");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_chk)
        else $error("read still pending while idle");

    a_chain_wb_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHAIN_WB) |-> (r_next < ENTRY_W'(r_eff)))
        else $error("chain freed an entry outside the table");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/block_alloc_table_engine_tb.sv =====
`timescale 1ns / 1ps

// self-checking bench for block_alloc_table_engine: directed table cases, a
// full-length chain walk and random phases under several register settings
// depends on bat_pkg and the engine rtl only
module block_alloc_table_engine_tb;
    import bat_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 6000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 600;
    localparam int IDLE_PCT     = 24;

    // mode codes the engine treats as no-ops
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic               chain_fault;
        logic               modified_flag;
        logic [ENTRY_W-1:0] found_block;
        logic [TOTAL_W-1:0] free_total;
        logic [ENTRY_W-1:0] read_value;
    } t_table_result;

    // shadow copy of the link table; predicts one result per accepted item
    class alloc_table_shadow;
        logic [ENTRY_W-1:0] links [MAX_ENTRIES];
        bit                 dirty;
        int unsigned        table_entries;
        int unsigned        block_count;
        t_table_result      pending_results [$];
        int unsigned        mismatches;
        int unsigned        chain_faults;
        int unsigned        mode_tally [8];

        function new();
            foreach (links[k]) links[k] = FREE_MARK;
            foreach (mode_tally[k]) mode_tally[k] = 0;
            dirty         = 1'b0;
            table_entries = 32'(CFG_RESET);
            block_count   = 32'(CFG_RESET);
            mismatches    = 0;
            chain_faults  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] value);
            if (sel == REG_TABLE_ENTRIES) begin
                table_entries = 32'(value);
            end else if (sel == REG_BLOCK_COUNT) begin
                block_count = 32'(value);
            end
        endfunction

        function int unsigned eff_size();
            return (table_entries < MAX_ENTRIES) ? table_entries : MAX_ENTRIES;
        endfunction

        function logic [ENTRY_W-1:0] entry_at(int unsigned idx);
            if (idx >= eff_size()) return FREE_MARK;
            return links[idx];
        endfunction

        function void store(int unsigned idx, logic [ENTRY_W-1:0] value);
            if (idx >= eff_size()) return;
            links[idx] = value;
            dirty      = 1'b1;
        endfunction

        function t_table_result step_table(logic [MODE_W-1:0] mode, logic [ENTRY_W-1:0] idx,
                                           logic [ENTRY_W-1:0] val);
            t_table_result res;
            int unsigned   walk;
            int unsigned   hop;
            int unsigned   steps;
            int unsigned   i;
            res = '0;
            case (mode)
                MODE_READ: begin
                    res.read_value = entry_at(32'(idx));
                end
                MODE_WRITE: begin
                    store(32'(idx), val);
                end
                MODE_COUNT: begin
                    for (i = 0; i < block_count; i++) begin
                        if (entry_at(i) == FREE_MARK) begin
                            res.free_total = res.free_total + TOTAL_W'(1);
                        end
                    end
                end
                MODE_FIND: begin
                    res.found_block = FREE_MARK;
                    for (i = block_count; i > 0; i--) begin
                        if (entry_at(i - 1) == FREE_MARK) begin
                            res.found_block = ENTRY_W'(i - 1);
                            break;
                        end
                    end
                end
                MODE_CHAIN: begin
                    walk  = 32'(idx);
                    steps = 0;
                    while (walk != END_MARK && walk != FREE_MARK) begin
                        if (steps >= MAX_ENTRIES) begin
                            res.chain_fault = 1'b1;
                            break;
                        end
                        hop  = walk;
                        walk = 32'(entry_at(hop));
                        store(hop, FREE_MARK);
                        steps++;
                    end
                end
                MODE_CLEAR: begin
                    dirty = 1'b0;
                end
                default: begin
                end
            endcase
            res.modified_flag = dirty;
            return res;
        endfunction

        function void note_item(logic [MODE_W-1:0] mode, logic [ENTRY_W-1:0] idx,
                                logic [ENTRY_W-1:0] val);
            t_table_result res;
            res = step_table(mode, idx, val);
            if (res.chain_fault) chain_faults++;
            mode_tally[mode]++;
            pending_results.push_back(res);
        endfunction

        function void compare_field(string field, logic [ENTRY_W-1:0] want,
                                    logic [ENTRY_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            t_table_result want;
            if (pending_results.size() == 0) begin
                $error("result item with nothing outstanding: %h", word);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("read_value", want.read_value, word[15:0]);
            compare_field("free_total", ENTRY_W'(want.free_total), ENTRY_W'(word[24:16]));
            compare_field("found_block", want.found_block, word[40:25]);
            compare_field("modified_flag", ENTRY_W'(want.modified_flag), ENTRY_W'(word[41]));
            compare_field("chain_fault", ENTRY_W'(want.chain_fault), ENTRY_W'(word[42]));
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    // fields from bit 0: mode[2:0], entry_index[18:3], entry_value[34:19], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // fields from bit 0: read_value[15:0], free_total[24:16], found_block[40:25],
    // modified_flag[41], chain_fault[42], zero pad
    wire  [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [CFG_W-1:0]       i_cfg_wdata   = '0;

    alloc_table_shadow shadow = new();

    bit calm         = 1'b0;
    int hold_asked   = 0;
    int hold_done    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;
    int reg_writes   = 0;

    block_alloc_table_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // result side: check, then decide the next ready (random, long hold or always)
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) shadow.check_result(m_axis_tdata);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_left - 1;
            end else if (hold_asked != hold_done) begin
                m_axis_tready <= 1'b0;
                hold_left     <= HOLD_CYCLES;
                hold_done     <= hold_asked;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_item(logic [MODE_W-1:0] mode, logic [ENTRY_W-1:0] idx,
                             logic [ENTRY_W-1:0] val);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - MODE_W - 2 * ENTRY_W){1'b0}}, val, idx, mode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        shadow.note_item(mode, idx, val);
        items_sent++;
    endtask

    // registers only change once every outstanding result is back
    task automatic settle_for_config();
        s_axis_tvalid <= 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= sel;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        shadow.set_reg(sel, value);
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [ENTRY_W-1:0] pick_index();
        int unsigned r;
        int unsigned eff;
        r   = $urandom_range(99);
        eff = shadow.eff_size();
        if (r < 70 && eff > 0) return ENTRY_W'($urandom_range(eff - 1));
        if (r < 80) return ENTRY_W'(eff + $urandom_range(3));
        if (r < 85) return (r[0]) ? END_MARK : FREE_MARK;
        return ENTRY_W'($urandom());
    endfunction

    function automatic logic [ENTRY_W-1:0] pick_link();
        int unsigned r;
        int unsigned eff;
        r   = $urandom_range(99);
        eff = shadow.eff_size();
        if (r < 50 && eff > 0) return ENTRY_W'($urandom_range(eff - 1));
        if (r < 70) return END_MARK;
        if (r < 80) return FREE_MARK;
        return ENTRY_W'($urandom());
    endfunction

    task automatic random_op();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 22) begin
            send_item(MODE_READ, pick_index(), ENTRY_W'($urandom()));
        end else if (pick < 52) begin
            send_item(MODE_WRITE, pick_index(), pick_link());
        end else if (pick < 60) begin
            send_item(MODE_COUNT, ENTRY_W'($urandom()), ENTRY_W'($urandom()));
        end else if (pick < 68) begin
            send_item(MODE_FIND, ENTRY_W'($urandom()), ENTRY_W'($urandom()));
        end else if (pick < 82) begin
            send_item(MODE_CHAIN, pick_index(), ENTRY_W'($urandom()));
        end else if (pick < 92) begin
            send_item(MODE_CLEAR, ENTRY_W'($urandom()), ENTRY_W'($urandom()));
        end else begin
            send_item(pick[0] ? MODE_SPARE_HI : MODE_SPARE_LO, ENTRY_W'($urandom()),
                      ENTRY_W'($urandom()));
        end
    endtask

    // link a short run of entries, then free it from the head
    task automatic build_and_free_chain();
        logic [ENTRY_W-1:0] hops [12];
        logic [ENTRY_W-1:0] tail;
        int unsigned        eff;
        int unsigned        len;
        int unsigned        k;
        eff = shadow.eff_size();
        if (eff == 0) begin
            send_item(MODE_CHAIN, pick_index(), ENTRY_W'($urandom()));
            return;
        end
        len = $urandom_range(1, (eff < 12) ? eff : 12);
        for (k = 0; k < len; k++) hops[k] = ENTRY_W'($urandom_range(eff - 1));
        case ($urandom_range(3))
            0: tail = END_MARK;
            1: tail = FREE_MARK;
            2: tail = ENTRY_W'($urandom_range(32'hFFF9, eff));
            default: tail = hops[$urandom_range(len - 1)];
        endcase
        for (k = 0; k < len; k++) begin
            send_item(MODE_WRITE, hops[k], (k + 1 < len) ? hops[k + 1] : tail);
            if ($urandom_range(9) == 0) random_op();
        end
        send_item(MODE_CHAIN, hops[0], ENTRY_W'($urandom()));
    endtask

    task automatic run_directed();
        send_item(MODE_READ, 16'd0, 16'd0);
        send_item(MODE_READ, 16'hFFFF, 16'hFFFF);
        // write beyond the table is dropped and leaves the mark clear
        send_item(MODE_WRITE, 16'hFFFF, 16'hAAAA);
        // unchanged value still sets the mark
        send_item(MODE_WRITE, 16'd3, FREE_MARK);
        send_item(MODE_CLEAR, 16'd0, 16'd0);
        send_item(MODE_WRITE, 16'd0, 16'h0000);
        send_item(MODE_WRITE, 16'd255, 16'hFFFF);
        send_item(MODE_COUNT, 16'd0, 16'd0);
        send_item(MODE_FIND, 16'd0, 16'd0);
        send_item(MODE_WRITE, 16'd10, 16'd11);
        send_item(MODE_WRITE, 16'd11, 16'd12);
        send_item(MODE_WRITE, 16'd12, END_MARK);
        send_item(MODE_CHAIN, 16'd10, 16'h5555);
        send_item(MODE_CHAIN, END_MARK, 16'd0);
        send_item(MODE_CHAIN, FREE_MARK, 16'd0);
        send_item(MODE_SPARE_LO, 16'hFFFF, 16'hFFFF);
        send_item(MODE_SPARE_HI, 16'h1234, 16'h8765);
        send_item(MODE_READ, 16'd255, 16'd0);
        settle_for_config();
        write_reg(REG_BLOCK_COUNT, '0);
        send_item(MODE_COUNT, 16'd0, 16'd0);
        send_item(MODE_FIND, 16'd0, 16'd0);
        // empty table: every index reads free, scans run past it
        settle_for_config();
        write_reg(REG_TABLE_ENTRIES, '0);
        write_reg(REG_BLOCK_COUNT, 9'd3);
        send_item(MODE_READ, 16'd0, 16'd0);
        send_item(MODE_WRITE, 16'd5, 16'd1);
        send_item(MODE_CHAIN, 16'd7, 16'd0);
        send_item(MODE_COUNT, 16'd0, 16'd0);
        send_item(MODE_FIND, 16'd0, 16'd0);
    endtask

    // every entry on one chain whose last link leaves the table: walk hits the limit
    task automatic run_full_chain();
        int unsigned order [MAX_ENTRIES];
        int unsigned k;
        int unsigned j;
        int unsigned swap;
        settle_for_config();
        write_reg(REG_TABLE_ENTRIES, CFG_RESET);
        write_reg(REG_BLOCK_COUNT, CFG_RESET);
        for (k = 0; k < MAX_ENTRIES; k++) order[k] = k;
        for (k = MAX_ENTRIES - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            swap     = order[k];
            order[k] = order[j];
            order[j] = swap;
        end
        for (k = 0; k + 1 < MAX_ENTRIES; k++) begin
            send_item(MODE_WRITE, ENTRY_W'(order[k]), ENTRY_W'(order[k + 1]));
        end
        send_item(MODE_WRITE, ENTRY_W'(order[MAX_ENTRIES - 1]),
                  ENTRY_W'($urandom_range(32'hFFF9, MAX_ENTRIES)));
        send_item(MODE_CHAIN, ENTRY_W'(order[0]), ENTRY_W'($urandom()));
        send_item(MODE_COUNT, 16'd0, 16'd0);
    endtask

    task automatic run_phase(logic [CFG_W-1:0] entries, logic [CFG_W-1:0] blocks, int count,
                             bit quiet, bit squeeze);
        int  start;
        bit  pressed;
        settle_for_config();
        write_reg(REG_TABLE_ENTRIES, entries);
        write_reg(REG_BLOCK_COUNT, blocks);
        calm    <= quiet;
        start   = items_sent;
        pressed = 1'b0;
        while (items_sent - start < count) begin
            if (squeeze && !pressed && items_sent - start >= 20) begin
                hold_asked <= hold_asked + 1;
                pressed    = 1'b1;
            end
            if ($urandom_range(99) < 15) begin
                build_and_free_chain();
            end else begin
                random_op();
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_full_chain();
        run_phase(CFG_RESET, CFG_RESET, 120, 1'b0, 1'b1);
        run_phase(9'd100, CFG_RESET, 100, 1'b0, 1'b0);
        run_phase(CFG_RESET, 9'd100, 100, 1'b0, 1'b0);
        run_phase(9'd1, 9'd1, 60, 1'b0, 1'b0);
        run_phase('0, CFG_RESET, 40, 1'b0, 1'b0);
        run_phase(CFG_W'($urandom_range(CFG_RESET)), CFG_W'($urandom_range(CFG_RESET)), 100,
                  1'b0, 1'b0);
        run_phase(CFG_RESET, CFG_RESET, 120, 1'b1, 1'b0);
        run_phase(CFG_W'($urandom_range(CFG_RESET)), CFG_W'($urandom_range(CFG_RESET)), 100,
                  1'b0, 1'b0);

        settle_for_config();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (shadow.pending_results.size() != 0) begin
            $error("%0d expected results never arrived", shadow.pending_results.size());
            shadow.mismatches += shadow.pending_results.size();
        end

        $display("%0d items: %0d rd %0d wr %0d cnt %0d find %0d chain %0d clr %0d spare",
                 items_sent, shadow.mode_tally[MODE_READ], shadow.mode_tally[MODE_WRITE],
                 shadow.mode_tally[MODE_COUNT], shadow.mode_tally[MODE_FIND],
                 shadow.mode_tally[MODE_CHAIN], shadow.mode_tally[MODE_CLEAR],
                 shadow.mode_tally[MODE_SPARE_LO] + shadow.mode_tally[MODE_SPARE_HI]);
        $display("%0d chain walks hit the step limit, %0d register writes, %0d mismatches",
                 shadow.chain_faults, reg_writes, shadow.mismatches);
        if (shadow.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bat_pkg.sv
sv/block_alloc_table_engine.sv
tb/sv/block_alloc_table_engine_tb.sv
